/* src/sle_pkg.sv */
// Shared types, field layout and defaults for the sequential list engine.
package sle_pkg;

  // Default sizing handed to the top-level parameters.
  localparam int DEPTH_DEF      = 128;
  localparam int WORD_WIDTH_DEF = 32;

  // Field widths of one input transaction and one result transaction.
  localparam int ACT_W   = 3;
  localparam int POS_W   = 8;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 1;
  localparam int FOUND_W = 8;
  localparam int LEN_W   = 8;

  // Input tdata layout, lowest bits first, padded to whole bytes.
  localparam int IN_ACT_LSB   = 0;
  localparam int IN_POS_LSB   = IN_ACT_LSB + ACT_W;
  localparam int IN_VALUE_LSB = IN_POS_LSB + POS_W;
  localparam int IN_USED_W    = IN_VALUE_LSB + VALUE_W;
  localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout, lowest bits first, padded to whole bytes.
  localparam int OUT_STAT_LSB  = 0;
  localparam int OUT_RDV_LSB   = OUT_STAT_LSB + STAT_W;
  localparam int OUT_FOUND_LSB = OUT_RDV_LSB + VALUE_W;
  localparam int OUT_LEN_LSB   = OUT_FOUND_LSB + FOUND_W;
  localparam int OUT_USED_W    = OUT_LEN_LSB + LEN_W;
  localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_GET    = 3'd2,
    ACT_LOCATE = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new input transaction
    logic init;    // set up the walk pointer and its end
    logic step;    // read one entry and advance the pointer
    logic commit;  // update the length and load the result register
  } sle_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_need;  // the action has entries to visit
    logic walk_last;  // the pointer sits on the last entry to visit
  } sle_stat_t;

endpackage

/* src/sle_ctrl.sv */
// Controller state machine of the sequential list engine.
module sle_ctrl import sle_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  sle_stat_t stat,
  output sle_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  // The result register may be reloaded once its current transaction leaves.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = stat.walk_need ? ST_WALK : ST_FINISH;
      end
      ST_WALK: begin
        if (stat.walk_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready   = (state == ST_IDLE);
    cmd.load   = s_tvalid && (state == ST_IDLE);
    cmd.init   = (state == ST_CHECK);
    cmd.step   = (state == ST_WALK);
    cmd.commit = (state == ST_FINISH) && out_free;
  end

  // The last read of a walk always precedes the drain cycle.
  a_drain_after_walk: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> $past(state) == ST_WALK)
    else $error("drain entered without a walk");

  // A new transaction is never taken while a walk or a commit is under way.
  a_load_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !cmd.step && !cmd.commit && !cmd.init)
    else $error("input accepted during an operation");

endmodule

/* src/sle_datapath.sv */
// Datapath of the sequential list engine: list memory, walk pointer and result register.
module sle_datapath import sle_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  sle_cmd_t               cmd,
  output sle_stat_t              stat,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int W  = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [WORD_WIDTH-1:0] mem [DEPTH];

  logic [ACT_W-1:0]      act;
  logic [POS_W-1:0]      pos;
  logic [VALUE_W-1:0]    value;
  logic [CW-1:0]         count;
  logic [AW-1:0]         ptr;
  logic [AW-1:0]         end_addr;
  logic                  dir_dn;
  logic                  rvalid_d;
  logic [AW-1:0]         src_d;
  logic [WORD_WIDTH-1:0] rdata;
  logic [VALUE_W-1:0]    rd_val;
  logic [FOUND_W-1:0]    found;
  logic                  hit;
  logic [OUT_TDATA_W-1:0] result;

  action_t               act_e;
  logic [WORD_WIDTH-1:0] word;
  logic [W-1:0]          pos_w;
  logic [W-1:0]          cnt_w;
  logic [W-1:0]          pos_m1_w;
  logic [W-1:0]          cnt_m1_w;
  logic [W-1:0]          src_p1_w;
  logic [W-1:0]          count_next_w;
  logic [AW-1:0]         pos_addr;
  logic [AW-1:0]         last_addr;
  logic                  ins_ok;
  logic                  pos_ok;
  logic                  op_ok;
  logic                  mv_we;
  logic                  ins_we;
  logic                  we;
  logic [AW-1:0]         mv_addr;
  logic [AW-1:0]         waddr;
  logic [WORD_WIDTH-1:0] wdata;

  assign act_e     = action_t'(act);
  assign word      = WORD_WIDTH'(value);
  assign pos_w     = W'(pos);
  assign cnt_w     = W'(count);
  assign pos_m1_w  = pos_w - W'(1);
  assign cnt_m1_w  = cnt_w - W'(1);
  assign src_p1_w  = W'(src_d) + W'(1);
  assign pos_addr  = pos_m1_w[AW-1:0];
  assign last_addr = cnt_m1_w[AW-1:0];

  assign ins_ok = (pos_w != '0) && (pos_w <= cnt_w + W'(1)) && (cnt_w < W'(DEPTH));
  assign pos_ok = (pos_w != '0) && (pos_w <= cnt_w);

  always_comb begin
    stat.walk_need = 1'b0;
    stat.walk_last = (ptr == end_addr);
    op_ok          = 1'b0;
    count_next_w   = cnt_w;
    case (act_e)
      ACT_INSERT: begin
        stat.walk_need = ins_ok && (pos_w <= cnt_w);
        op_ok          = ins_ok;
        if (ins_ok) begin
          count_next_w = cnt_w + W'(1);
        end
      end
      ACT_DELETE: begin
        stat.walk_need = pos_ok;
        op_ok          = pos_ok;
        if (pos_ok) begin
          count_next_w = cnt_m1_w;
        end
      end
      ACT_GET: begin
        stat.walk_need = pos_ok;
        op_ok          = pos_ok;
      end
      ACT_LOCATE: begin
        stat.walk_need = (count != '0);
        op_ok          = 1'b1;
      end
      ACT_CLEAR: begin
        op_ok        = 1'b1;
        count_next_w = '0;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  // Moves write each word one place from where it was read: up for an insert, down for a delete.
  assign mv_we   = rvalid_d && ((act_e == ACT_INSERT) ||
                   ((act_e == ACT_DELETE) && (src_d != pos_addr)));
  assign mv_addr = (act_e == ACT_INSERT) ? (src_d + AW'(1)) : (src_d - AW'(1));
  assign ins_we  = cmd.commit && (act_e == ACT_INSERT) && ins_ok;
  assign we      = mv_we || ins_we;
  assign waddr   = ins_we ? pos_addr : mv_addr;
  assign wdata   = ins_we ? word : rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.step) begin
      rdata <= mem[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      rvalid_d <= 1'b0;
      hit      <= 1'b0;
    end else begin
      rvalid_d <= cmd.step;
      if (cmd.load) begin
        hit <= 1'b0;
      end else if (rvalid_d && (act_e == ACT_LOCATE) && !hit && (rdata == word)) begin
        hit <= 1'b1;
      end
      if (cmd.commit) begin
        count <= count_next_w[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act    <= s_tdata[IN_ACT_LSB +: ACT_W];
      pos    <= s_tdata[IN_POS_LSB +: POS_W];
      value  <= s_tdata[IN_VALUE_LSB +: VALUE_W];
      rd_val <= '0;
      found  <= '0;
    end else if (rvalid_d) begin
      if (((act_e == ACT_DELETE) || (act_e == ACT_GET)) && (src_d == pos_addr)) begin
        rd_val <= VALUE_W'(rdata);
      end
      if ((act_e == ACT_LOCATE) && !hit && (rdata == word)) begin
        found <= src_p1_w[FOUND_W-1:0];
      end
    end
    if (cmd.init) begin
      case (act_e)
        ACT_INSERT: begin
          ptr      <= last_addr;
          end_addr <= pos_addr;
          dir_dn   <= 1'b1;
        end
        ACT_DELETE: begin
          ptr      <= pos_addr;
          end_addr <= last_addr;
          dir_dn   <= 1'b0;
        end
        ACT_GET: begin
          ptr      <= pos_addr;
          end_addr <= pos_addr;
          dir_dn   <= 1'b0;
        end
        default: begin
          ptr      <= '0;
          end_addr <= last_addr;
          dir_dn   <= 1'b0;
        end
      endcase
    end else if (cmd.step) begin
      ptr <= dir_dn ? (ptr - AW'(1)) : (ptr + AW'(1));
    end
    if (cmd.step) begin
      src_d <= ptr;
    end
    if (cmd.commit) begin
      result <= {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, count_next_w[LEN_W-1:0], found,
                 rd_val, !op_ok};
    end
  end

  assign m_tdata = result;

  // The list never holds more entries than the memory has rows.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    W'(count) <= W'(DEPTH))
    else $error("entry count beyond depth");

  // A move never writes the row that the walk is reading in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    we && cmd.step |-> waddr != ptr)
    else $error("read and write of one row in one cycle");

endmodule

/* src/sequential_list_engine_top.sv */
// Top level of the sequential list engine: stream ports, controller and datapath.
//
// The block keeps an ordered list of up to DEPTH words in a memory with one
// write port and one registered read port. Each input transaction carries one
// action (insert, delete, get, locate or clear) and produces exactly one result
// transaction with a status bit, the word read, the position found and the new
// list length. Actions are handled one at a time. Clear, a rejected action,
// a locate on an empty list and an insert at the end of the list pass from
// acceptance to the result register through the accept, check and finish
// states. Other inserts, deletes, gets and locates walk n entries through the
// memory read port at one entry per cycle, through the accept, check, walk,
// drain and finish states: insert walks the entries from the end down to its
// position, delete the entries from its position to the end, get walks one
// entry and locate walks the whole list. A finished result waits in an output
// register; the next transaction is accepted while it waits, and only the
// final commit of that next action waits for the register to drain.
module sequential_list_engine_top import sle_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // Fields from bit 0 up: action[2:0], position[10:3], value[42:11], zero pad.
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // Fields from bit 0 up: status[0], read_value[32:1], found_position[40:33],
  // list_length[48:41], zero pad.
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  sle_cmd_t  cmd;
  sle_stat_t stat;

  // The controller sequences each action and owns both handshakes.
  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the list memory, the length and the result register.
  sle_datapath #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .cmd     (cmd),
    .stat    (stat),
    .m_tdata (m_tdata)
  );

endmodule

/* tb/sequential_list_engine_top_tb.sv */
// Self-checking stream testbench for the sequential list engine top level.
`timescale 1ns / 1ps

module sequential_list_engine_top_tb;
  import sle_pkg::*;

  localparam int LIST_DEPTH    = DEPTH_DEF;
  localparam int WORD_W        = WORD_WIDTH_DEF;
  localparam int NUM_DIRECTED  = 25;
  localparam int RANDOM_ITEMS  = 1600;
  localparam int QUIET_TAIL    = 150;
  localparam int DRAIN_CYCLES  = 200;
  localparam int CYCLE_LIMIT   = 1200000;
  localparam int MAX_PRINTED   = 40;
  localparam int MAX_FILLS     = 4;

  // Action codes the package leaves unnamed; the block must reject them.
  localparam logic [ACT_W-1:0] ACT_RESERVED_5 = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RESERVED_6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RESERVED_7 = 3'd7;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // One result transaction, unpacked from m_tdata.
  typedef struct packed {
    logic               status;
    logic [VALUE_W-1:0] read_value;
    logic [FOUND_W-1:0] found_pos;
    logic [LEN_W-1:0]   length;
  } list_result_t;

  // One row of the directed part. Rows with has_typed set carry a result
  // written out by hand; the others are checked against the list predictor.
  typedef struct {
    logic [ACT_W-1:0]   act;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] val;
    bit                 has_typed;
    list_result_t       typed;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // Predictor state: its own copy of the list contents and length.
  logic [WORD_W-1:0] shadow_words [LIST_DEPTH];
  int unsigned       shadow_count;

  list_result_t pending_results [$];
  int           error_count   = 0;
  int           results_seen  = 0;
  int           items_sent    = 0;
  int           cycle_count   = 0;
  int           fills_done    = 0;
  bit           quiet         = 1'b0;
  bit           sender_gaps   = 1'b1;

  sequential_list_engine_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed table: empty-list errors, inserts at front, end and middle with
  // the extreme words, reads at both ends and past the end, the largest
  // position, locate hits and misses, deletes at both ends, the reserved
  // action codes, clear, and reads after clear while stale words remain.
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{ACT_GET,        8'd1,   32'h0,        1'b1, '{STATUS_ERR, 32'h0, 8'd0, 8'd0}},
    '{ACT_DELETE,     8'd1,   32'h0,        1'b1, '{STATUS_ERR, 32'h0, 8'd0, 8'd0}},
    '{ACT_INSERT,     8'd0,   32'h5,        1'b1, '{STATUS_ERR, 32'h0, 8'd0, 8'd0}},
    '{ACT_INSERT,     8'd2,   32'h5,        1'b1, '{STATUS_ERR, 32'h0, 8'd0, 8'd0}},
    '{ACT_LOCATE,     8'd0,   32'h0,        1'b1, '{STATUS_OK,  32'h0, 8'd0, 8'd0}},
    '{ACT_INSERT,     8'd1,   32'h7FFFFFFF, 1'b1, '{STATUS_OK,  32'h0, 8'd0, 8'd1}},
    '{ACT_INSERT,     8'd1,   32'h80000000, 1'b1, '{STATUS_OK,  32'h0, 8'd0, 8'd2}},
    '{ACT_INSERT,     8'd3,   32'hFFFFFFFF, 1'b1, '{STATUS_OK,  32'h0, 8'd0, 8'd3}},
    '{ACT_INSERT,     8'd2,   32'h0,        1'b0, '0},
    '{ACT_GET,        8'd4,   32'h0,        1'b1, '{STATUS_OK,  32'hFFFFFFFF, 8'd0, 8'd4}},
    '{ACT_GET,        8'd1,   32'h0,        1'b1, '{STATUS_OK,  32'h80000000, 8'd0, 8'd4}},
    '{ACT_GET,        8'd5,   32'h0,        1'b1, '{STATUS_ERR, 32'h0, 8'd0, 8'd4}},
    '{ACT_GET,        8'd255, 32'h0,        1'b1, '{STATUS_ERR, 32'h0, 8'd0, 8'd4}},
    '{ACT_INSERT,     8'd255, 32'h1,        1'b1, '{STATUS_ERR, 32'h0, 8'd0, 8'd4}},
    '{ACT_LOCATE,     8'd0,   32'h7FFFFFFF, 1'b0, '0},
    '{ACT_LOCATE,     8'd255, 32'h12345678, 1'b0, '0},
    '{ACT_LOCATE,     8'd0,   32'h0,        1'b0, '0},
    '{ACT_DELETE,     8'd1,   32'h0,        1'b0, '0},
    '{ACT_DELETE,     8'd3,   32'h0,        1'b0, '0},
    '{ACT_RESERVED_5, 8'd1,   32'h0,        1'b1, '{STATUS_ERR, 32'h0, 8'd0, 8'd2}},
    '{ACT_RESERVED_6, 8'd255, 32'hFFFFFFFF, 1'b1, '{STATUS_ERR, 32'h0, 8'd0, 8'd2}},
    '{ACT_RESERVED_7, 8'd0,   32'h0,        1'b1, '{STATUS_ERR, 32'h0, 8'd0, 8'd2}},
    '{ACT_CLEAR,      8'd0,   32'h0,        1'b1, '{STATUS_OK,  32'h0, 8'd0, 8'd0}},
    '{ACT_GET,        8'd1,   32'h0,        1'b1, '{STATUS_ERR, 32'h0, 8'd0, 8'd0}},
    '{ACT_LOCATE,     8'd0,   32'h0,        1'b0, '0}
  };

  // Applies one action to the shadow list and returns the result it causes.
  function automatic list_result_t apply_list_action(logic [ACT_W-1:0] act,
                                                     logic [POS_W-1:0] pos,
                                                     logic [VALUE_W-1:0] val);
    list_result_t r;
    int unsigned  p;
    r = '0;
    p = pos;
    case (act)
      ACT_INSERT: begin
        if (p < 1 || p > shadow_count + 1 || shadow_count >= LIST_DEPTH) begin
          r.status = STATUS_ERR;
        end else begin
          for (int j = shadow_count; j >= p; j--) shadow_words[j] = shadow_words[j-1];
          shadow_words[p-1] = val;
          shadow_count++;
        end
      end
      ACT_DELETE, ACT_GET: begin
        if (p < 1 || p > shadow_count) begin
          r.status = STATUS_ERR;
        end else begin
          r.read_value = shadow_words[p-1];
          if (act == ACT_DELETE) begin
            for (int j = p; j < shadow_count; j++) shadow_words[j-1] = shadow_words[j];
            shadow_count--;
          end
        end
      end
      ACT_LOCATE: begin
        // First match wins; later matches leave the found position unchanged.
        for (int j = 0; j < shadow_count; j++) begin
          if (shadow_words[j] == val && r.found_pos == '0) r.found_pos = FOUND_W'(j + 1);
        end
      end
      ACT_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
        r.status = STATUS_ERR;
      end
    endcase
    r.length = LEN_W'(shadow_count);
    return r;
  endfunction

  // Words lean toward the extremes and a few small values, so that locate
  // meets duplicates and the sign bit is exercised often.
  function automatic logic [VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return VALUE_W'($urandom_range(0, 7));
      3: return ~VALUE_W'($urandom_range(0, 7));
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                 logic [VALUE_W-1:0] want);
    if (error_count < MAX_PRINTED)
      $display("mismatch in result %0d, %s: got %h, expected %h",
               results_seen, what, got, want);
    error_count++;
  endtask

  // Offers one input transaction, waits for the handshake, then records what
  // the block has to answer. A short idle burst may come first.
  task automatic push_transaction(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                                  logic [VALUE_W-1:0] val, bit has_typed,
                                  list_result_t typed);
    list_result_t predicted;
    if (!quiet && sender_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - IN_USED_W){1'b0}}, val, pos, act};
    do @(posedge clk); while (!s_tready);
    predicted = apply_list_action(act, pos, val);
    pending_results.push_back(has_typed ? typed : predicted);
    items_sent++;
    if (items_sent >= NUM_DIRECTED + RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
  endtask

  // A well-formed action: positions inside the list, locate values mostly
  // taken from the list, inserts weighted so the list grows between clears.
  task automatic send_sound_action();
    int unsigned n;
    int          roll;
    n    = shadow_count;
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      push_transaction(ACT_CLEAR, POS_W'($urandom_range(0, 255)), pick_word(), 1'b0, '0);
    end else if (roll < 42 || n == 0) begin
      push_transaction(ACT_INSERT, POS_W'($urandom_range(1, n + 1)), pick_word(), 1'b0, '0);
    end else if (roll < 62) begin
      push_transaction(ACT_DELETE, POS_W'($urandom_range(1, n)), pick_word(), 1'b0, '0);
    end else if (roll < 80) begin
      push_transaction(ACT_GET, POS_W'($urandom_range(1, n)), pick_word(), 1'b0, '0);
    end else if ($urandom_range(0, 9) < 6) begin
      push_transaction(ACT_LOCATE, POS_W'($urandom_range(0, 255)),
                       shadow_words[$urandom_range(0, n - 1)], 1'b0, '0);
    end else begin
      push_transaction(ACT_LOCATE, POS_W'($urandom_range(0, 255)), pick_word(), 1'b0, '0);
    end
  endtask

  // Fills the list to capacity, then probes the full list: inserts that
  // must be refused, a locate near the far end, and reads of the last entry.
  task automatic fill_list_to_capacity();
    while (shadow_count < LIST_DEPTH) begin
      if ($urandom_range(0, 9) == 0)
        push_transaction(ACT_GET, POS_W'($urandom_range(1, shadow_count + 1)), pick_word(),
                         1'b0, '0);
      else
        push_transaction(ACT_INSERT, POS_W'($urandom_range(1, shadow_count + 1)),
                         VALUE_W'($urandom), 1'b0, '0);
    end
    push_transaction(ACT_INSERT, POS_W'($urandom_range(1, LIST_DEPTH + 1)), pick_word(),
                     1'b0, '0);
    push_transaction(ACT_INSERT, POS_W'(LIST_DEPTH + 1), pick_word(), 1'b0, '0);
    push_transaction(ACT_LOCATE, '0, shadow_words[LIST_DEPTH-1], 1'b0, '0);
    push_transaction(ACT_GET, POS_W'(LIST_DEPTH), pick_word(), 1'b0, '0);
    push_transaction(ACT_DELETE, POS_W'(LIST_DEPTH), pick_word(), 1'b0, '0);
    if ($urandom_range(0, 1) == 0) push_transaction(ACT_CLEAR, '0, '0, 1'b0, '0);
  endtask

  // Stimulus: reset, directed table, then random episodes until the item
  // budget is used up, then drain.
  initial begin : stimulus
    int roll;
    int burst;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      push_transaction(directed_rows[i].act, directed_rows[i].pos, directed_rows[i].val,
                       directed_rows[i].has_typed, directed_rows[i].typed);

    while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      roll        = $urandom_range(0, 99);
      if (roll < 5 && fills_done < MAX_FILLS) begin
        fill_list_to_capacity();
        fills_done++;
      end else if (roll < 85) begin
        burst = $urandom_range(8, 32);
        repeat (burst) send_sound_action();
      end else begin
        // Noise: any action code, any position, any word.
        burst = $urandom_range(4, 12);
        repeat (burst)
          push_transaction(ACT_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 255)),
                           pick_word(), 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("[sequential_list_engine_top] OK");
    else
      $display("[sequential_list_engine_top] ERROR");
    $finish;
  end

  // Result side back-pressure: short stall bursts between ready stretches,
  // now and then a long stretch with no stall, and none at all near the end.
  initial begin : result_pacing
    while (rst) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      m_tready <= 1'b1;
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(50, 200)) @(posedge clk);
      else
        repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Each accepted result is compared field by field with the oldest
  // pending expectation.
  always @(posedge clk) begin : result_check
    list_result_t want;
    list_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status     = m_tdata[OUT_STAT_LSB];
      got.read_value = m_tdata[OUT_RDV_LSB +: VALUE_W];
      got.found_pos  = m_tdata[OUT_FOUND_LSB +: FOUND_W];
      got.length     = m_tdata[OUT_LEN_LSB +: LEN_W];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", m_tdata[VALUE_W-1:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", VALUE_W'(got.status), VALUE_W'(want.status));
        if (got.read_value !== want.read_value)
          report_mismatch("read_value", got.read_value, want.read_value);
        if (got.found_pos !== want.found_pos)
          report_mismatch("found_position", VALUE_W'(got.found_pos), VALUE_W'(want.found_pos));
        if (got.length !== want.length)
          report_mismatch("list_length", VALUE_W'(got.length), VALUE_W'(want.length));
      end
      results_seen++;
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[sequential_list_engine_top] ERROR");
      $finish;
    end
  end

endmodule

/* sim.f */
src/sle_pkg.sv
src/sle_ctrl.sv
src/sle_datapath.sv
src/sequential_list_engine_top.sv
tb/sequential_list_engine_top_tb.sv
